FILE: hw/rtl/ssdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssdf_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int RAW_W     = 16;
    localparam int GAIN_W    = 24;
    localparam int OFFSET_W  = 24;
    localparam int STEP_W    = 26;
    localparam int SCALED_W  = 25;
    localparam int MS_W      = 10;
    localparam int SEC_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 26;

    // Product of raw sample and gain, and the millisecond accumulator in Q16.
    localparam int PROD_W = RAW_W + GAIN_W;
    localparam int FRAC_W = 16;
    localparam int ACC_W  = 26;

    // Packet framing.
    localparam logic [BYTE_W-1:0] HDR0     = 8'h40;
    localparam logic [BYTE_W-1:0] HDR1     = 8'h23;
    localparam logic [BYTE_W-1:0] HDR2     = 8'h24;
    localparam logic [BYTE_W-1:0] CHK_SEED = 8'h50;

    // One second in Q16 milliseconds.
    localparam logic [ACC_W:0] MS_LIMIT_Q16 = 27'd65536000;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

    // Register reset values.
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'h010000;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 24'h000000;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 26'h0010000;

    // Default queue depths.
    localparam int MID_DEPTH_DEFAULT = 2;
    localparam int OUT_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_q16;
        logic [OFFSET_W-1:0] offset;
        logic [STEP_W-1:0]   ms_step_q16;
    } cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0]           raw_sample;
        logic signed [SCALED_W-1:0] scaled_sample;
        logic [MS_W-1:0]            time_ms;
        logic [SEC_W-1:0]           time_seconds;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/serial_sample_packet_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial sample packet deframer. Bytes from a serial link enter on the push
// side at up to one byte per clock. Six-byte packets ('@' '#' '$', data high,
// data low, checksum = 0x50 ^ high ^ low) are found by a sliding header
// search; packets with a bad checksum vanish without a trace. Each good
// packet yields one result: the raw 16-bit sample, the scaled sample
// ((raw * gain_q16) >> 16) - offset as a 25-bit two's complement value, and
// a timestamp in milliseconds and whole seconds. After its checksum byte is
// transferred, a result passes through the sample queue and the registered
// multiply stage into the result queue, where it waits until popped. The
// push side sustains one byte per clock as long as results are popped; full
// rises only when the sample queue between framing and arithmetic backs up.
// Write the registers (0 gain, 1 offset, 2 ms step) only while no packet is
// in flight; writes are taken in every cycle.
module serial_sample_packet_deframer_core #(
    parameter int MID_DEPTH = ssdf_pkg::MID_DEPTH_DEFAULT,
    parameter int OUT_DEPTH = ssdf_pkg::OUT_DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [ssdf_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [ssdf_pkg::RAW_W-1:0]              raw_sample,
    output logic signed [ssdf_pkg::SCALED_W-1:0]    scaled_sample,
    output logic [ssdf_pkg::MS_W-1:0]               time_ms,
    output logic [ssdf_pkg::SEC_W-1:0]              time_seconds,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ssdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ssdf_pkg::CFG_DAT_W-1:0]     cfg_data
);

    import ssdf_pkg::*;

    cfg_t             cfg_reg;
    logic             byte_transfer;
    logic             sample_push;
    logic [RAW_W-1:0] sample_wr;
    logic [RAW_W-1:0] sample_rd;
    logic             sample_full;
    logic             sample_empty;
    logic             sample_pop;
    logic             result_full;
    logic             result_push;
    result_t          result_wr;
    result_t          result_rd;

    assign cfg_ready     = 1'b1;
    assign full          = sample_full;
    assign byte_transfer = push && !sample_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q16    <= GAIN_RESET;
            cfg_reg.offset      <= OFFSET_RESET;
            cfg_reg.ms_step_q16 <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN:   cfg_reg.gain_q16    <= cfg_data[GAIN_W-1:0];
                REG_OFFSET: cfg_reg.offset      <= cfg_data[OFFSET_W-1:0];
                REG_STEP:   cfg_reg.ms_step_q16 <= cfg_data[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Framing front end.
    ssdf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_transfer),
        .byte_data   (rx_byte),
        .sample_push (sample_push),
        .sample_data (sample_wr)
    );

    // Queue of good samples between framing and arithmetic.
    ssdf_fifo #(
        .WIDTH (RAW_W),
        .DEPTH (MID_DEPTH)
    ) u_sample_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (sample_push),
        .wr_data (sample_wr),
        .full    (sample_full),
        .pop     (sample_pop),
        .rd_data (sample_rd),
        .empty   (sample_empty)
    );

    // Scaling and timestamp back end.
    ssdf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_empty (sample_empty),
        .sample_data  (sample_rd),
        .sample_pop   (sample_pop),
        .result_full  (result_full),
        .result_push  (result_push),
        .result_data  (result_wr)
    );

    // Result queue facing the consumer.
    ssdf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (result_push),
        .wr_data (result_wr),
        .full    (result_full),
        .pop     (pop),
        .rd_data (result_rd),
        .empty   (empty)
    );

    assign raw_sample    = result_rd.raw_sample;
    assign scaled_sample = result_rd.scaled_sample;
    assign time_ms       = result_rd.time_ms;
    assign time_seconds  = result_rd.time_seconds;

endmodule

`default_nettype wire

FILE: hw/rtl/ssdf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] LIMIT = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == LIMIT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ssdf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          byte_valid,
    input  wire logic [ssdf_pkg::BYTE_W-1:0]   byte_data,
    output logic                               sample_push,
    output logic [ssdf_pkg::RAW_W-1:0]         sample_data
);

    import ssdf_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_CHK  = 2'd3;

    localparam logic [3*BYTE_W-1:0] HEADER = {HDR0, HDR1, HDR2};

    logic [1:0]          phase_reg, phase_next;
    logic [3*BYTE_W-1:0] window_reg, window_next;
    logic [1:0]          fill_reg, fill_next;
    logic [BYTE_W-1:0]   high_reg, high_next;
    logic [BYTE_W-1:0]   low_reg, low_next;
    logic [3*BYTE_W-1:0] window_shift;
    logic [1:0]          fill_inc;
    logic                checksum_ok;

    assign window_shift = {window_reg[2*BYTE_W-1:0], byte_data};
    assign fill_inc     = (fill_reg == 2'd3) ? 2'd3 : fill_reg + 2'd1;
    assign checksum_ok  = ((CHK_SEED ^ high_reg ^ low_reg) == byte_data);
    assign sample_data  = {high_reg, low_reg};

    // Framing state machine: hunt for the header, then collect two data
    // bytes and check the checksum byte.
    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        sample_push = 1'b0;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (fill_inc == 2'd3 && window_shift == HEADER)
                    begin
                        phase_next  = PH_HIGH;
                        window_next = '0;
                        fill_next   = '0;
                    end
                    else
                    begin
                        window_next = window_shift;
                        fill_next   = fill_inc;
                    end
                end
                PH_HIGH:
                begin
                    high_next  = byte_data;
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    low_next   = byte_data;
                    phase_next = PH_CHK;
                end
                PH_CHK:
                begin
                    phase_next  = PH_HUNT;
                    window_next = '0;
                    fill_next   = '0;
                    sample_push = checksum_ok;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            fill_reg   <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ssdf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdf_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ssdf_pkg::cfg_t              cfg,
    input  wire logic                        sample_empty,
    input  wire logic [ssdf_pkg::RAW_W-1:0]  sample_data,
    output logic                             sample_pop,
    input  wire logic                        result_full,
    output logic                             result_push,
    output ssdf_pkg::result_t                result_data
);

    import ssdf_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [RAW_W-1:0]   s1_raw_reg;
    logic [MS_W-1:0]    s1_ms_reg;
    logic [SEC_W-1:0]   s1_sec_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [PROD_W-1:0]  prod_c;
    logic [ACC_W:0]     ms_sum;
    logic               ms_wrap;
    logic               s1_load;

    // Stage handshake: the stage register refills when empty or when its
    // content is moved into the result queue.
    assign result_push   = s1_valid_reg && !result_full;
    assign s1_load       = !s1_valid_reg || result_push;
    assign sample_pop    = s1_load && !sample_empty;
    assign s1_valid_next = sample_pop ? 1'b1 : (result_push ? 1'b0 : s1_valid_reg);

    // Scaling multiply, registered before the offset subtraction.
    assign prod_c = PROD_W'(sample_data) * PROD_W'(cfg.gain_q16);

    // Timestamp advance, committed as each sample leaves the queue.
    assign ms_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(cfg.ms_step_q16);
    assign ms_wrap = (ms_sum >= MS_LIMIT_Q16);
    assign acc_next = ms_wrap ? '0 : ms_sum[ACC_W-1:0];
    assign sec_next = ms_wrap ? sec_reg + 1'b1 : sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            sec_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (sample_pop)
            begin
                acc_reg <= acc_next;
                sec_reg <= sec_next;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (sample_pop)
        begin
            s1_prod_reg <= prod_c;
            s1_raw_reg  <= sample_data;
            s1_ms_reg   <= acc_next[ACC_W-1:FRAC_W];
            s1_sec_reg  <= sec_next;
        end
    end

    // Truncate the product to whole units and subtract the offset.
    always_comb
    begin
        result_data.raw_sample    = s1_raw_reg;
        result_data.scaled_sample = SCALED_W'(s1_prod_reg[PROD_W-1:FRAC_W])
                                    - SCALED_W'(cfg.offset);
        result_data.time_ms       = s1_ms_reg;
        result_data.time_seconds  = s1_sec_reg;
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ssdf_pkg::*;

    // Cycles that a checksum byte needs to reach the result side, with margin.
    localparam int SETTLE_CYCLES = 8;
    // Longest stretch without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    // Length of the deliberate receiver hold-off.
    localparam int HOLD_CYCLES   = 200;
    localparam int ROUNDS        = 9;
    localparam int ROUND_ITEMS   = 120;

    // The register space has four slots; the last one is not decoded.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [STEP_W-1:0] STEP_ONE_SEC = 26'd65536000;

    typedef enum logic [1:0] {
        HUNT,
        WANT_HIGH,
        WANT_LOW,
        WANT_CHECK
    } frame_phase_e;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                known;
        result_t           want;
    } byte_row_t;

    localparam result_t NO_RESULT = '0;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [BYTE_W-1:0]          rx_byte;
    logic                       empty;
    logic                       pop;
    logic [RAW_W-1:0]           raw_sample;
    logic signed [SCALED_W-1:0] scaled_sample;
    logic [MS_W-1:0]            time_ms;
    logic [SEC_W-1:0]           time_seconds;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DAT_W-1:0]       cfg_data;

    // Shadow copy of the framer, the arithmetic and the registers.
    frame_phase_e        fr_phase    = HUNT;
    logic [23:0]         hdr_window  = '0;
    int unsigned         hdr_fill    = 0;
    logic [BYTE_W-1:0]   data_hi     = '0;
    logic [BYTE_W-1:0]   data_lo     = '0;
    logic [ACC_W:0]      ms_acc      = '0;
    logic [SEC_W-1:0]    sec_count   = '0;
    logic [GAIN_W-1:0]   gain_reg    = GAIN_RESET;
    logic [OFFSET_W-1:0] offset_reg  = OFFSET_RESET;
    logic [STEP_W-1:0]   step_reg    = STEP_RESET;

    result_t     pending_samples[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned quiet_cycles   = 0;
    bit          sender_calm    = 1'b0;
    bit          receiver_calm  = 1'b0;
    bit          hold_off_req   = 1'b0;

    // Directed bytes under the reset register values: gain 1.0, no offset,
    // one millisecond per sample.
    byte_row_t directed_rows [27] = '{
        // Clean packet with all-zero data.
        '{8'h40, 1'b0, NO_RESULT}, '{8'h23, 1'b0, NO_RESULT}, '{8'h24, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h50, 1'b1, '{16'h0000, 25'h0000000, 10'd1, 32'd0}},
        // Doubled '@' forces the search to slide by one byte; all-ones data.
        '{8'h40, 1'b0, NO_RESULT}, '{8'h40, 1'b0, NO_RESULT}, '{8'h23, 1'b0, NO_RESULT},
        '{8'h24, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'h50, 1'b1, '{16'hFFFF, 25'h000FFFF, 10'd2, 32'd0}},
        // Bad checksum that itself looks like '@', then the rest of a header:
        // the search restarts empty, so no packet may be found here.
        '{8'h40, 1'b0, NO_RESULT}, '{8'h23, 1'b0, NO_RESULT}, '{8'h24, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT}, '{8'h34, 1'b0, NO_RESULT}, '{8'h40, 1'b0, NO_RESULT},
        '{8'h23, 1'b0, NO_RESULT}, '{8'h24, 1'b0, NO_RESULT},
        // Header found after the leftovers; data bytes that look like header.
        '{8'h40, 1'b0, NO_RESULT}, '{8'h23, 1'b0, NO_RESULT}, '{8'h24, 1'b0, NO_RESULT},
        '{8'h40, 1'b0, NO_RESULT}, '{8'h23, 1'b0, NO_RESULT},
        '{8'h33, 1'b1, '{16'h4023, 25'h0004023, 10'd3, 32'd0}}
    };

    serial_sample_packet_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .raw_sample    (raw_sample),
        .scaled_sample (scaled_sample),
        .time_ms       (time_ms),
        .time_seconds  (time_seconds),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Advance the shadow framer by one byte; returns 1 when a good packet ends.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t sample_out);
        logic [PROD_W-1:0] product;
        logic [ACC_W:0]    acc_sum;
        sample_out = NO_RESULT;
        case (fr_phase)
            HUNT:
            begin
                hdr_window = {hdr_window[15:0], b};
                if (hdr_fill < 3)
                    hdr_fill++;
                if (hdr_fill == 3 && hdr_window == {HDR0, HDR1, HDR2})
                begin
                    fr_phase   = WANT_HIGH;
                    hdr_window = '0;
                    hdr_fill   = 0;
                end
                return 1'b0;
            end
            WANT_HIGH:
            begin
                data_hi  = b;
                fr_phase = WANT_LOW;
                return 1'b0;
            end
            WANT_LOW:
            begin
                data_lo  = b;
                fr_phase = WANT_CHECK;
                return 1'b0;
            end
            default:
            begin
                // The checksum byte closes the packet whether or not it matches.
                fr_phase   = HUNT;
                hdr_window = '0;
                hdr_fill   = 0;
                if ((CHK_SEED ^ data_hi ^ data_lo) != b)
                    return 1'b0;
                product = {data_hi, data_lo} * gain_reg;
                acc_sum = ms_acc + {1'b0, step_reg};
                if (acc_sum >= MS_LIMIT_Q16)
                begin
                    ms_acc    = '0;
                    sec_count = sec_count + 1'b1;
                end
                else
                begin
                    ms_acc = acc_sum;
                end
                sample_out.raw_sample    = {data_hi, data_lo};
                sample_out.scaled_sample = {1'b0, product[PROD_W-1:FRAC_W]} - {1'b0, offset_reg};
                sample_out.time_ms       = ms_acc[FRAC_W+MS_W-1:FRAC_W];
                sample_out.time_seconds  = sec_count;
                return 1'b1;
            end
        endcase
    endfunction

    // Random bytes, with extremes and header bytes favored.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return HDR0;
            3: return HDR1;
            4: return HDR2;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Offer one byte, wait for its transfer and record what it should produce.
    task automatic feed_byte(input logic [BYTE_W-1:0] b, input bit known, input result_t want);
        result_t predicted;
        bit      produced;
        if (!sender_calm && $urandom_range(99) < 9)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        produced = deframe_byte(b, predicted);
        if (known)
            pending_samples.push_back(want);
        else if (produced)
            pending_samples.push_back(predicted);
    endtask

    // Random traffic: mostly whole packets, some noise and broken headers.
    task automatic send_stream(input int unsigned n_items);
        int unsigned       start;
        int unsigned       kind;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] chk;
        start = bytes_sent;
        while (bytes_sent - start < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                feed_byte(pick_byte(), 1'b0, NO_RESULT);
            end
            else if (kind < 15)
            begin
                feed_byte(HDR0, 1'b0, NO_RESULT);
                feed_byte(HDR1, 1'b0, NO_RESULT);
                feed_byte(pick_byte(), 1'b0, NO_RESULT);
            end
            else
            begin
                hi  = pick_byte();
                lo  = pick_byte();
                chk = CHK_SEED ^ hi ^ lo;
                if ($urandom_range(99) < 12)
                    chk = chk ^ BYTE_W'($urandom_range(255, 1));
                feed_byte(HDR0, 1'b0, NO_RESULT);
                feed_byte(HDR1, 1'b0, NO_RESULT);
                feed_byte(HDR2, 1'b0, NO_RESULT);
                feed_byte(hi, 1'b0, NO_RESULT);
                feed_byte(lo, 1'b0, NO_RESULT);
                feed_byte(chk, 1'b0, NO_RESULT);
            end
        end
    endtask

    // Stop sending, let every expected result arrive, then let the pipe settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four register slots back to back; valid stays high in between.
    task automatic write_regs(input logic [CFG_DAT_W-1:0] gain_val,
                              input logic [CFG_DAT_W-1:0] offset_val,
                              input logic [CFG_DAT_W-1:0] step_val);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DAT_W-1:0] val [4];
        idx = '{REG_GAIN, REG_OFFSET, REG_STEP, REG_SPARE};
        val = '{gain_val, offset_val, step_val, CFG_DAT_W'($urandom())};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[k])
                REG_GAIN:   gain_reg   = val[k][GAIN_W-1:0];
                REG_OFFSET: offset_reg = val[k][OFFSET_W-1:0];
                REG_STEP:   step_reg   = val[k][STEP_W-1:0];
                default:    ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus: reset, directed bytes, then rounds of random traffic.
    initial
    begin : stimulus
        logic [CFG_DAT_W-1:0] g;
        logic [CFG_DAT_W-1:0] o;
        logic [CFG_DAT_W-1:0] s;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        rx_byte   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GAIN;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            feed_byte(directed_rows[i].rx, directed_rows[i].known, directed_rows[i].want);
        wait_drained();

        for (int round = 0; round < ROUNDS; round++)
        begin
            g = CFG_DAT_W'($urandom());
            o = CFG_DAT_W'($urandom());
            if ($urandom_range(3) == 0)
                s = CFG_DAT_W'($urandom());
            else if ($urandom_range(1) == 0)
                s = CFG_DAT_W'($urandom_range(65536 * 40));
            else
                s = CFG_DAT_W'($urandom_range(STEP_ONE_SEC));
            case (round)
                0: write_regs('1, 24'hFFFFFF, '1);
                1: write_regs('0, '0, '0);
                2: write_regs('0, 24'hFFFFFF, STEP_ONE_SEC);
                3: write_regs(24'hFFFFFF, '0, STEP_ONE_SEC - 1'b1);
                4: write_regs(GAIN_RESET, OFFSET_RESET, STEP_RESET);
                default: write_regs(g, o, s);
            endcase
            sender_calm   = (round == 5);
            receiver_calm = (round == 5);
            // Round 6 starves the result side so the input backs up.
            if (round == 6)
                hold_off_req = 1'b1;
            send_stream(ROUND_ITEMS);
            wait_drained();
        end

        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Result side: random pop stalls, one long hold-off on request.
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!receiver_calm && $urandom_range(99) < 9)
            begin
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t ns: unexpected result, raw %h scaled %h ms %0d s %0d",
                         $time, raw_sample, scaled_sample, time_ms, time_seconds);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                check_field("raw_sample", want.raw_sample, raw_sample);
                check_field("scaled_sample", want.scaled_sample, scaled_sample);
                check_field("time_ms", want.time_ms, time_ms);
                check_field("time_seconds", want.time_seconds, time_seconds);
            end
        end
    end

    // Hang detection: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule
